// ===== rtl/core/tiwp_pkg.sv =====
// Shared types and codes for the transaction input and witness parser.
package tiwp_pkg;

  localparam logic [1:0] KIND_INPUT  = 2'd0;
  localparam logic [1:0] KIND_ITEM   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_NIN_VARINT  = 4'd2;
  localparam logic [3:0] ST_COUNT_RANGE = 4'd3;
  localparam logic [3:0] ST_OUTPOINT    = 4'd4;
  localparam logic [3:0] ST_SS_VARINT   = 4'd5;
  localparam logic [3:0] ST_SS_TRUNC    = 4'd6;
  localparam logic [3:0] ST_NOUT_VARINT = 4'd7;
  localparam logic [3:0] ST_OUT_TRUNC   = 4'd8;
  localparam logic [3:0] ST_OS_VARINT   = 4'd9;
  localparam logic [3:0] ST_OS_TRUNC    = 4'd10;
  localparam logic [3:0] ST_WCNT_VARINT = 4'd11;
  localparam logic [3:0] ST_TOO_MANY    = 4'd12;
  localparam logic [3:0] ST_ILEN_VARINT = 4'd13;
  localparam logic [3:0] ST_ITEM_TRUNC  = 4'd14;

  localparam logic [15:0] MAX_INPUTS_RESET = 16'd20000;

  // One result item as it travels from the parser to the output queue.
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] input_index;
    logic [2:0]  item_index;
    logic [21:0] data_offset;
    logic [22:0] data_length;
    logic [21:0] outpoint_offset;
    logic [3:0]  status;
    logic [15:0] input_count;
  } rec_t;

endpackage

// ===== rtl/core/tiwp_if.sv =====
// Handshake interfaces for the byte input and the record output channels.
interface tiwp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

interface tiwp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] input_index;
  logic [2:0]  item_index;
  logic [21:0] data_offset;
  logic [22:0] data_length;
  logic [21:0] outpoint_offset;
  logic [3:0]  status;
  logic [15:0] input_count;
  modport source (output valid, output record_kind, output input_index, output item_index,
                  output data_offset, output data_length, output outpoint_offset,
                  output status, output input_count, input ready);
  modport sink (input valid, input record_kind, input input_index, input item_index,
                input data_offset, input data_length, input outpoint_offset,
                input status, input input_count, output ready);
endinterface

// ===== rtl/core/tiwp_parser.sv =====
// Front end: per-byte phase machine that decodes varints and builds records.
module tiwp_parser #(
  parameter int MAX_TX_BYTES      = 4194304,
  parameter int MAX_WITNESS_ITEMS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           byte_valid,
  input  logic [7:0]     tx_byte,
  input  logic           last_byte,
  output logic           rec_valid,
  output tiwp_pkg::rec_t rec
);
  import tiwp_pkg::*;

  localparam int OFF_W  = $clog2(MAX_TX_BYTES + 1);
  localparam int SKIP_W = OFF_W + 1;
  localparam int ITEM_W = $clog2(MAX_WITNESS_ITEMS + 1);
  localparam logic [OFF_W-1:0] OFF_MAX  = OFF_W'(MAX_TX_BYTES);
  localparam logic [63:0]      LEN_MAX  = 64'(MAX_TX_BYTES);
  localparam logic [63:0]      ITEM_MAX = 64'(MAX_WITNESS_ITEMS);

  localparam logic [3:0] PH_VERSION = 4'd0;
  localparam logic [3:0] PH_MARK    = 4'd1;
  localparam logic [3:0] PH_FLAG    = 4'd2;
  localparam logic [3:0] PH_NIN     = 4'd3;
  localparam logic [3:0] PH_OUTPT   = 4'd4;
  localparam logic [3:0] PH_SSLEN   = 4'd5;
  localparam logic [3:0] PH_SSSKIP  = 4'd6;
  localparam logic [3:0] PH_NOUT    = 4'd7;
  localparam logic [3:0] PH_OVAL    = 4'd8;
  localparam logic [3:0] PH_OSLEN   = 4'd9;
  localparam logic [3:0] PH_OSSKIP  = 4'd10;
  localparam logic [3:0] PH_WCNT    = 4'd11;
  localparam logic [3:0] PH_WLEN    = 4'd12;
  localparam logic [3:0] PH_WSKIP   = 4'd13;
  localparam logic [3:0] PH_DONE    = 4'd14;
  localparam logic [3:0] PH_HALT    = 4'd15;

  logic [15:0]       max_inputs;
  logic [3:0]        phase, phase_next;
  logic [OFF_W-1:0]  byte_offset, byte_offset_next;
  logic [63:0]       varint_value, varint_value_next;
  logic [3:0]        varint_left, varint_left_next;
  logic [2:0]        varint_idx, varint_idx_next;
  logic [SKIP_W-1:0] skip_remaining, skip_remaining_next;
  logic [15:0]       input_counter, input_counter_next;
  logic [15:0]       input_total, input_total_next;
  logic [OFF_W-1:0]  output_remaining, output_remaining_next;
  logic [ITEM_W-1:0] item_counter, item_counter_next;
  logic [ITEM_W-1:0] item_total, item_total_next;
  logic              segwit_flag, segwit_flag_next;
  logic [3:0]        first_error, first_error_next;
  logic [OFF_W-1:0]  outpoint_at, outpoint_at_next;

  logic [3:0]  vphase;
  logic        vdone;
  logic [63:0] v;
  logic [3:0]  st;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_inputs <= MAX_INPUTS_RESET;
    end else if (cfg_we) begin
      max_inputs <= cfg_wdata;
    end
  end

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_next            = phase;
    varint_value_next     = varint_value;
    varint_left_next      = varint_left;
    varint_idx_next       = varint_idx;
    skip_remaining_next   = skip_remaining;
    input_counter_next    = input_counter;
    input_total_next      = input_total;
    output_remaining_next = output_remaining;
    item_counter_next     = item_counter;
    item_total_next       = item_total;
    segwit_flag_next      = segwit_flag;
    first_error_next      = first_error;
    outpoint_at_next      = outpoint_at;
    rec_valid             = 1'b0;
    rec                   = '0;
    vphase                = phase;
    vdone                 = 1'b0;
    v                     = '0;
    st                    = ST_OK;

    byte_offset_next = (byte_offset < OFF_MAX) ? byte_offset + 1'b1 : byte_offset;

    // Marker, flag, varint and skipped bytes are handled here; vdone flags a completed value.
    if (phase == PH_MARK && tx_byte == 8'h00) begin
      phase_next = PH_FLAG;
    end else if (phase == PH_FLAG) begin
      if (tx_byte == 8'h01) begin
        segwit_flag_next = 1'b1;
        phase_next       = PH_NIN;
      end else begin
        first_error_next = ST_COUNT_RANGE;
        phase_next       = PH_HALT;
      end
    end else if (phase == PH_MARK || phase == PH_NIN || phase == PH_SSLEN ||
                 phase == PH_NOUT || phase == PH_OSLEN || phase == PH_WCNT ||
                 phase == PH_WLEN) begin
      if (phase == PH_MARK) begin
        vphase     = PH_NIN;
        phase_next = PH_NIN;
      end
      if (varint_left == 4'd0) begin
        if (tx_byte < 8'hfd) begin
          vdone = 1'b1;
          v     = 64'(tx_byte);
        end else begin
          varint_left_next  = (tx_byte == 8'hfd) ? 4'd2 : (tx_byte == 8'hfe) ? 4'd4 : 4'd8;
          varint_value_next = '0;
          varint_idx_next   = '0;
        end
      end else begin
        varint_value_next = varint_value | (64'(tx_byte) << {varint_idx, 3'b000});
        varint_idx_next   = varint_idx + 1'b1;
        varint_left_next  = varint_left - 1'b1;
        if (varint_left == 4'd1) begin
          vdone = 1'b1;
          v     = varint_value_next;
        end
      end
    end else if (phase == PH_VERSION || phase == PH_OUTPT || phase == PH_SSSKIP ||
                 phase == PH_OVAL || phase == PH_OSSKIP || phase == PH_WSKIP) begin
      if (skip_remaining != '0) skip_remaining_next = skip_remaining - 1'b1;
      if (skip_remaining_next == '0) begin
        case (phase)
          PH_VERSION: phase_next = PH_MARK;
          PH_OUTPT:   phase_next = PH_SSLEN;
          PH_OVAL:    phase_next = PH_OSLEN;
          PH_SSSKIP: begin
            input_counter_next = input_counter + 1'b1;
            if (input_counter_next < input_total) begin
              phase_next          = PH_OUTPT;
              skip_remaining_next = SKIP_W'(36);
              outpoint_at_next    = byte_offset_next;
            end else begin
              phase_next = PH_NOUT;
            end
          end
          PH_OSSKIP: begin
            output_remaining_next = output_remaining - 1'b1;
            if (output_remaining_next != '0) begin
              phase_next = PH_OVAL; skip_remaining_next = SKIP_W'(8);
            end else if (segwit_flag) begin
              input_counter_next = '0; phase_next = PH_WCNT;
            end else begin
              phase_next = PH_DONE;
            end
          end
          PH_WSKIP: begin
            item_counter_next = item_counter + 1'b1;
            if (item_counter_next < item_total) begin
              phase_next = PH_WLEN;
            end else begin
              input_counter_next = input_counter + 1'b1;
              phase_next = (input_counter_next < input_total) ? PH_WCNT : PH_DONE;
            end
          end
          default: phase_next = phase;
        endcase
      end
    end

    // Act on a completed varint according to the phase it belongs to.
    if (vdone) begin
      case (vphase)
        PH_NIN: begin
          if (v == 64'd0 || v > 64'(max_inputs)) begin
            first_error_next = ST_COUNT_RANGE; phase_next = PH_HALT;
          end else begin
            input_total_next    = v[15:0];
            input_counter_next  = '0;
            phase_next          = PH_OUTPT;
            skip_remaining_next = SKIP_W'(36);
            outpoint_at_next    = byte_offset_next;
          end
        end
        PH_SSLEN: begin
          if (v > LEN_MAX) begin
            first_error_next = ST_SS_TRUNC; phase_next = PH_HALT;
          end else begin
            rec_valid           = 1'b1;
            rec.record_kind     = KIND_INPUT;
            rec.input_index     = input_counter;
            rec.data_offset     = 22'(byte_offset_next);
            rec.data_length     = 23'(v);
            rec.outpoint_offset = 22'(outpoint_at);
            skip_remaining_next = SKIP_W'(v) + SKIP_W'(4);
            phase_next          = PH_SSSKIP;
          end
        end
        PH_NOUT, PH_OSLEN: begin
          if (v > LEN_MAX) begin
            first_error_next = (vphase == PH_NOUT) ? ST_OUT_TRUNC : ST_OS_TRUNC;
            phase_next       = PH_HALT;
          end else if (vphase == PH_OSLEN && v != 64'd0) begin
            skip_remaining_next = SKIP_W'(v);
            phase_next          = PH_OSSKIP;
          end else begin
            output_remaining_next = (vphase == PH_NOUT) ? OFF_W'(v)
                                                        : output_remaining - 1'b1;
            if (output_remaining_next != '0) begin
              phase_next = PH_OVAL; skip_remaining_next = SKIP_W'(8);
            end else if (segwit_flag) begin
              input_counter_next = '0; phase_next = PH_WCNT;
            end else begin
              phase_next = PH_DONE;
            end
          end
        end
        PH_WCNT: begin
          if (v > ITEM_MAX) begin
            first_error_next = ST_TOO_MANY; phase_next = PH_HALT;
          end else begin
            item_total_next   = ITEM_W'(v);
            item_counter_next = '0;
            if (v != 64'd0) begin
              phase_next = PH_WLEN;
            end else begin
              input_counter_next = input_counter + 1'b1;
              phase_next = (input_counter_next < input_total) ? PH_WCNT : PH_DONE;
            end
          end
        end
        PH_WLEN: begin
          if (v > LEN_MAX) begin
            first_error_next = ST_ITEM_TRUNC; phase_next = PH_HALT;
          end else begin
            rec_valid       = 1'b1;
            rec.record_kind = KIND_ITEM;
            rec.input_index = input_counter;
            rec.item_index  = 3'(item_counter);
            rec.data_offset = 22'(byte_offset_next);
            rec.data_length = 23'(v);
            if (v == 64'd0) begin
              item_counter_next = item_counter + 1'b1;
              if (item_counter_next < item_total) begin
                phase_next = PH_WLEN;
              end else begin
                input_counter_next = input_counter + 1'b1;
                phase_next = (input_counter_next < input_total) ? PH_WCNT : PH_DONE;
              end
            end else begin
              skip_remaining_next = SKIP_W'(v);
              phase_next          = PH_WSKIP;
            end
          end
        end
        default: phase_next = phase_next;
      endcase
    end

    // Final byte: report one status and return to the start state.
    if (last_byte) begin
      if (byte_offset_next < OFF_W'(10)) begin
        st = ST_SHORT;
      end else begin
        case (phase_next)
          PH_OUTPT:  st = ST_OUTPOINT;
          PH_SSLEN:  st = ST_SS_VARINT;
          PH_SSSKIP: st = ST_SS_TRUNC;
          PH_NOUT:   st = ST_NOUT_VARINT;
          PH_OVAL:   st = ST_OUT_TRUNC;
          PH_OSLEN:  st = ST_OS_VARINT;
          PH_OSSKIP: st = ST_OS_TRUNC;
          PH_WCNT:   st = ST_WCNT_VARINT;
          PH_WLEN:   st = ST_ILEN_VARINT;
          PH_WSKIP:  st = ST_ITEM_TRUNC;
          PH_DONE:   st = ST_OK;
          PH_HALT:   st = first_error_next;
          default:   st = ST_NIN_VARINT;
        endcase
      end
      rec_valid       = 1'b1;
      rec             = '0;
      rec.record_kind = KIND_STATUS;
      rec.status      = st;
      rec.input_count = (st == ST_OK) ? input_total_next : 16'd0;
    end
  end

  // Parse state registers, cleared at reset and after each final byte.
  always_ff @(posedge clk) begin
    if (rst || (byte_valid && last_byte)) begin
      phase            <= PH_VERSION;
      byte_offset      <= '0;
      varint_value     <= '0;
      varint_left      <= '0;
      varint_idx       <= '0;
      skip_remaining   <= SKIP_W'(4);
      input_counter    <= '0;
      input_total      <= '0;
      output_remaining <= '0;
      item_counter     <= '0;
      item_total       <= '0;
      segwit_flag      <= 1'b0;
      first_error      <= ST_OK;
      outpoint_at      <= '0;
    end else if (byte_valid) begin
      phase            <= phase_next;
      byte_offset      <= byte_offset_next;
      varint_value     <= varint_value_next;
      varint_left      <= varint_left_next;
      varint_idx       <= varint_idx_next;
      skip_remaining   <= skip_remaining_next;
      input_counter    <= input_counter_next;
      input_total      <= input_total_next;
      output_remaining <= output_remaining_next;
      item_counter     <= item_counter_next;
      item_total       <= item_total_next;
      segwit_flag      <= segwit_flag_next;
      first_error      <= first_error_next;
      outpoint_at      <= outpoint_at_next;
    end
  end

endmodule

// ===== rtl/core/tiwp_queue.sv =====
// Back end: short record queue that drives the output channel.
module tiwp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tiwp_pkg::rec_t push_rec,
  output logic           space,
  tiwp_out_if.source     out_ch
);
  import tiwp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  rec_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;
  rec_t             head;

  assign space = (count != (PTR_W + 1)'(DEPTH));
  assign pop   = out_ch.valid && out_ch.ready;
  assign head  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  // Output channel shows the head record.
  always_comb begin
    out_ch.valid           = (count != '0);
    out_ch.record_kind     = head.record_kind;
    out_ch.input_index     = head.input_index;
    out_ch.item_index      = head.item_index;
    out_ch.data_offset     = head.data_offset;
    out_ch.data_length     = head.data_length;
    out_ch.outpoint_offset = head.outpoint_offset;
    out_ch.status          = head.status;
    out_ch.input_count     = head.input_count;
  end

endmodule

// ===== rtl/core/tx_input_witness_parser.sv =====
// Top level of the streaming transaction input and witness parser.
//
// The in_ch channel takes one transaction byte per item, with last_byte set
// on the final byte. The out_ch channel gives input records (on each
// completed scriptSig length), witness item records (on each completed item
// length) and one status record per transaction on its final byte.
// Each byte causes at most one record. A record is written into the queue
// when its byte is accepted and shows on out_ch once it is at the queue head.
// Throughput is one byte per cycle while the queue has space: the phase
// machine updates all of its counters for a byte at once.
// A four-entry record queue sits between the parser and out_ch. While the
// receiver stalls, bytes are still taken until the queue is full; then
// in_ch.ready drops until a record leaves.
// Reset clears the parser, empties the queue and sets max_inputs to 20000.
// cfg_we with cfg_wdata writes max_inputs; write it only while idle.
// After each final byte the parser returns to its start state.
module tx_input_witness_parser #(
  parameter int MAX_TX_BYTES      = 4194304,
  parameter int MAX_WITNESS_ITEMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  tiwp_in_if.sink     in_ch,
  tiwp_out_if.source  out_ch
);
  import tiwp_pkg::*;

  logic space;
  logic accept;
  logic rec_valid;
  rec_t rec;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  tiwp_parser #(
    .MAX_TX_BYTES     (MAX_TX_BYTES),
    .MAX_WITNESS_ITEMS(MAX_WITNESS_ITEMS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_valid(accept),
    .tx_byte   (in_ch.tx_byte),
    .last_byte (in_ch.last_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  tiwp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept && rec_valid),
    .push_rec(rec),
    .space   (space),
    .out_ch  (out_ch)
  );

endmodule

// ===== test/tb_tx_input_witness_parser.sv =====
// Testbench for the transaction input and witness parser: random and directed byte streams.
`timescale 1ns / 100ps

module tb_tx_input_witness_parser;
  import tiwp_pkg::*;

  localparam int unsigned MAX_TX  = 4194304;
  localparam int unsigned MAX_WIT = 8;
  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned BYTE_TARGET  = 1550;

  typedef enum int {
    PH_VER, PH_MARK, PH_FLAG, PH_NIN, PH_OUTPT, PH_SSLEN, PH_SSSKIP, PH_NOUT,
    PH_OVAL, PH_OSLEN, PH_OSSKIP, PH_WCNT, PH_WLEN, PH_WSKIP, PH_DONE, PH_HALT
  } parse_phase_e;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  tiwp_in_if  in_ch ();
  tiwp_out_if out_ch ();

  tx_input_witness_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Parser shadow state.
  logic [15:0]       max_in;
  parse_phase_e      ph;
  int unsigned       boff;
  longint unsigned   vval;
  int unsigned       vleft;
  int unsigned       vshift;
  longint unsigned   skip_left;
  longint unsigned   outs_left;
  int unsigned       in_idx;
  int unsigned       in_total;
  int unsigned       wit_idx;
  int unsigned       wit_total;
  bit                segw;
  logic [3:0]        err_code;
  int unsigned       opnt_at;
  bit                rec_valid;
  rec_t              rec_next;

  rec_t              pending_records[$];
  logic [7:0]        tx_bytes[$];

  int unsigned nerr;
  int unsigned nbytes;
  int unsigned ntx;
  int unsigned nrecords;
  int unsigned cycles;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned hold_req;

  always #4 clk = ~clk;

  // Stop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_tx_input_witness_parser: FAIL");
      $finish;
    end
  end

  function automatic rec_t mk_rec(logic [1:0] kind, longint unsigned idx, longint unsigned item,
                                  longint unsigned off, longint unsigned len,
                                  longint unsigned op);
    rec_t r;
    r = '0;
    r.record_kind = kind;
    r.input_index = idx[15:0];
    r.item_index = item[2:0];
    r.data_offset = off[21:0];
    r.data_length = len[22:0];
    r.outpoint_offset = op[21:0];
    return r;
  endfunction

  function automatic void clear_parse();
    ph = PH_VER; boff = 0; vval = 0; vleft = 0; vshift = 0; skip_left = 4;
    in_idx = 0; in_total = 0; outs_left = 0; wit_idx = 0; wit_total = 0;
    segw = 0; err_code = ST_OK; opnt_at = 0;
  endfunction

  function automatic void latch_err(logic [3:0] code);
    err_code = code;
    ph = PH_HALT;
  endfunction

  function automatic void begin_outpoint();
    ph = PH_OUTPT; skip_left = 36; opnt_at = boff;
  endfunction

  function automatic void next_wit_item();
    if (wit_idx < wit_total) begin
      ph = PH_WLEN;
    end else begin
      in_idx++;
      ph = (in_idx < in_total) ? PH_WCNT : PH_DONE;
    end
  endfunction

  function automatic void next_output();
    if (outs_left != 0) begin
      ph = PH_OVAL; skip_left = 8;
    end else if (segw) begin
      in_idx = 0; ph = PH_WCNT;
    end else begin
      ph = PH_DONE;
    end
  endfunction

  // A length or count has been fully decoded.
  function automatic void length_complete(longint unsigned v);
    case (ph)
      PH_NIN: begin
        if (v == 0 || v > max_in) latch_err(ST_COUNT_RANGE);
        else begin
          in_total = v; in_idx = 0; begin_outpoint();
        end
      end
      PH_SSLEN: begin
        if (v > MAX_TX) latch_err(ST_SS_TRUNC);
        else begin
          rec_next = mk_rec(KIND_INPUT, in_idx, 0, boff, v, opnt_at); rec_valid = 1;
          skip_left = v + 4; ph = PH_SSSKIP;
        end
      end
      PH_NOUT: begin
        if (v > MAX_TX) latch_err(ST_OUT_TRUNC);
        else begin
          outs_left = v; next_output();
        end
      end
      PH_OSLEN: begin
        if (v > MAX_TX) latch_err(ST_OS_TRUNC);
        else if (v == 0) begin
          outs_left--; next_output();
        end else begin
          skip_left = v; ph = PH_OSSKIP;
        end
      end
      PH_WCNT: begin
        if (v > MAX_WIT) latch_err(ST_TOO_MANY);
        else begin
          wit_total = v; wit_idx = 0; next_wit_item();
        end
      end
      PH_WLEN: begin
        if (v > MAX_TX) latch_err(ST_ITEM_TRUNC);
        else begin
          rec_next = mk_rec(KIND_ITEM, in_idx, wit_idx, boff, v, 0); rec_valid = 1;
          if (v == 0) begin
            wit_idx++; next_wit_item();
          end else begin
            skip_left = v; ph = PH_WSKIP;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // CompactSize decoding, one byte at a time.
  function automatic void feed_compact(logic [7:0] b);
    if (vleft == 0) begin
      if (b < 8'hfd) length_complete(b);
      else begin
        vleft = (b == 8'hfd) ? 2 : (b == 8'hfe) ? 4 : 8;
        vval = 0; vshift = 0;
      end
    end else begin
      vval |= longint'(b) << vshift;
      vshift += 8; vleft--;
      if (vleft == 0) length_complete(vval);
    end
  endfunction

  // Predicts the record caused by one accepted byte and queues it.
  function automatic void predict_byte(logic [7:0] b, bit last);
    rec_t st_rec;
    logic [3:0] st;
    rec_valid = 0;
    if (boff < MAX_TX) boff++;
    case (ph)
      PH_MARK: begin
        if (b == 8'h00) ph = PH_FLAG;
        else begin
          ph = PH_NIN; feed_compact(b);
        end
      end
      PH_FLAG: begin
        if (b == 8'h01) begin
          segw = 1; ph = PH_NIN;
        end else latch_err(ST_COUNT_RANGE);
      end
      PH_NIN, PH_SSLEN, PH_NOUT, PH_OSLEN, PH_WCNT, PH_WLEN: feed_compact(b);
      PH_VER, PH_OUTPT, PH_SSSKIP, PH_OVAL, PH_OSSKIP, PH_WSKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          case (ph)
            PH_VER: ph = PH_MARK;
            PH_OUTPT: ph = PH_SSLEN;
            PH_SSSKIP: begin
              in_idx++;
              if (in_idx < in_total) begin_outpoint();
              else ph = PH_NOUT;
            end
            PH_OVAL: ph = PH_OSLEN;
            PH_OSSKIP: begin
              outs_left--; next_output();
            end
            default: begin
              wit_idx++; next_wit_item();
            end
          endcase
        end
      end
      default: ;
    endcase

    if (last) begin
      if (boff < 10) st = ST_SHORT;
      else begin
        case (ph)
          PH_OUTPT: st = ST_OUTPOINT;
          PH_SSLEN: st = ST_SS_VARINT;
          PH_SSSKIP: st = ST_SS_TRUNC;
          PH_NOUT: st = ST_NOUT_VARINT;
          PH_OVAL: st = ST_OUT_TRUNC;
          PH_OSLEN: st = ST_OS_VARINT;
          PH_OSSKIP: st = ST_OS_TRUNC;
          PH_WCNT: st = ST_WCNT_VARINT;
          PH_WLEN: st = ST_ILEN_VARINT;
          PH_WSKIP: st = ST_ITEM_TRUNC;
          PH_DONE: st = ST_OK;
          PH_HALT: st = err_code;
          default: st = ST_NIN_VARINT;
        endcase
      end
      st_rec = '0;
      st_rec.record_kind = KIND_STATUS;
      st_rec.status = st;
      st_rec.input_count = (st == ST_OK) ? in_total[15:0] : 16'd0;
      pending_records.push_back(st_rec);
      clear_parse();
    end else if (rec_valid) begin
      pending_records.push_back(rec_next);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      nerr++;
    end
  endfunction

  // Compare each record that leaves the block with the oldest prediction.
  always @(posedge clk) begin
    rec_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      nrecords++;
      if (pending_records.size() == 0) begin
        $error("record_kind: expected none, got %0d", out_ch.record_kind);
        nerr++;
      end else begin
        e = pending_records.pop_front();
        check_field("record_kind", e.record_kind, out_ch.record_kind);
        check_field("input_index", e.input_index, out_ch.input_index);
        check_field("item_index", e.item_index, out_ch.item_index);
        check_field("data_offset", e.data_offset, out_ch.data_offset);
        check_field("data_length", e.data_length, out_ch.data_length);
        check_field("outpoint_offset", e.outpoint_offset, out_ch.outpoint_offset);
        check_field("status", e.status, out_ch.status);
        check_field("input_count", e.input_count, out_ch.input_count);
      end
    end
  end

  // Receiver: changing stall patterns, plus long hold-offs on request.
  always @(posedge clk) begin
    int unsigned hold_left;
    int unsigned rx_mode;
    int unsigned mode_age;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    mode_age++;
    if (mode_age > 150) begin
      mode_age = 0;
      rx_mode = $urandom_range(0, 3);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= (cycles % 16 < 5);
      endcase
    end
  end

  // Offers one byte and waits for it to be taken; gaps fall between bursts.
  task automatic send_byte(logic [7:0] b, bit last);
    in_ch.valid <= 1'b1;
    in_ch.tx_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, last);
    nbytes++;
    if (burst_left != 0) burst_left--;
    else if (gaps_on) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Sends the whole transaction, then idles the input.
  task automatic send_tx();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i], i == tx_bytes.size() - 1);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    ntx++;
  endtask

  task automatic wait_drained();
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_inputs(logic [15:0] v);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_in = v;
  endtask

  // CompactSize encoding, sometimes with a longer form than needed.
  task automatic push_compact(longint unsigned v);
    if (v < 253 && $urandom_range(0, 5) != 0) begin
      tx_bytes.push_back(v[7:0]);
    end else if (v <= 64'hffff) begin
      tx_bytes.push_back(8'hfd);
      for (int i = 0; i < 2; i++) tx_bytes.push_back(v[8*i +: 8]);
    end else if (v <= 64'hffffffff) begin
      tx_bytes.push_back(8'hfe);
      for (int i = 0; i < 4; i++) tx_bytes.push_back(v[8*i +: 8]);
    end else begin
      tx_bytes.push_back(8'hff);
      for (int i = 0; i < 8; i++) tx_bytes.push_back(v[8*i +: 8]);
    end
  endtask

  function automatic longint unsigned huge_len();
    case ($urandom_range(0, 2))
      0: return MAX_TX;
      1: return MAX_TX + 1;
      default: return {$urandom(), $urandom()} | 64'h1_0000_0000;
    endcase
  endfunction

  // Builds a transaction; bad_field selects one length made oversized, after
  // which the transaction ends.
  // bad_field: 0 none, 1 scriptSig, 2 output count, 3 output script,
  // 4 witness count above the limit, 5 witness item.
  task automatic build_tx(bit sw, longint unsigned nin, int unsigned nout, int unsigned bad_field);
    int unsigned len;
    int unsigned wcnt;
    tx_bytes.delete();
    repeat (4) tx_bytes.push_back($urandom_range(0, 255));
    if (sw) begin
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'h01);
    end
    push_compact(nin);
    for (int i = 0; i < nin; i++) begin
      repeat (36) tx_bytes.push_back($urandom_range(0, 255));
      if (bad_field == 1 && i == nin - 1) begin
        push_compact(huge_len());
        return;
      end
      len = $urandom_range(0, 6);
      push_compact(len);
      repeat (len + 4) tx_bytes.push_back($urandom_range(0, 255));
    end
    if (bad_field == 2) begin
      push_compact(huge_len());
      return;
    end
    push_compact(nout);
    for (int i = 0; i < nout; i++) begin
      repeat (8) tx_bytes.push_back($urandom_range(0, 255));
      if (bad_field == 3 && i == nout - 1) begin
        push_compact(huge_len());
        return;
      end
      len = $urandom_range(0, 5);
      push_compact(len);
      repeat (len) tx_bytes.push_back($urandom_range(0, 255));
    end
    if (sw) begin
      for (int i = 0; i < nin; i++) begin
        wcnt = (bad_field == 4) ? MAX_WIT + 1 :
               ($urandom_range(0, 7) == 0) ? MAX_WIT : $urandom_range(0, 3);
        push_compact(wcnt);
        if (bad_field == 4) return;
        for (int k = 0; k < wcnt; k++) begin
          if (bad_field == 5) begin
            push_compact(huge_len());
            return;
          end
          len = $urandom_range(0, 5);
          push_compact(len);
          repeat (len) tx_bytes.push_back($urandom_range(0, 255));
        end
      end
    end
    // Sometimes trailing bytes that the parser ignores.
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) tx_bytes.push_back($urandom);
  endtask

  // Short streams, marker without flag, well-formed and oversized lengths.
  task automatic test_directed();
    gaps_on = 0;
    tx_bytes = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01};
    send_tx();
    tx_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h11, 8'h22, 8'h33};
    send_tx();
    build_tx(0, 1, 0, 0);
    send_tx();
    build_tx(1, 2, 1, 0);
    send_tx();
    for (int f = 1; f <= 5; f++) begin
      build_tx(f[0], 1, 1, f);
      send_tx();
    end
    gaps_on = 1;
  endtask

  // The input-count limit at its extremes and in between.
  task automatic test_input_limit();
    write_max_inputs(16'd1);
    build_tx(1, 1, 1, 0);
    send_tx();
    build_tx(0, 2, 1, 0);
    send_tx();
    write_max_inputs(16'hffff);
    build_tx(0, 64'hffff, 0, 0);
    tx_bytes = tx_bytes[0:15];
    send_tx();
    build_tx(0, 64'h10000, 0, 0);
    tx_bytes = tx_bytes[0:12];
    send_tx();
    write_max_inputs(16'd3);
    for (int n = 0; n <= 5; n++) begin
      build_tx($urandom_range(0, 1), n, 1, 0);
      send_tx();
    end
    write_max_inputs($urandom_range(2, 65534));
    build_tx(1, 3, 2, 0);
    send_tx();
    write_max_inputs(MAX_INPUTS_RESET);
  endtask

  // The receiver holds off while bytes keep coming, so the block stalls its input.
  task automatic test_backpressure();
    gaps_on = 0;
    wait_drained();
    hold_req = 400;
    build_tx(1, 12, 2, 0);
    send_tx();
    wait_drained();
    gaps_on = 1;
  endtask

  // Mostly well-formed transactions; some truncated, corrupted or pure noise.
  task automatic test_random();
    int unsigned pick;
    int unsigned cut;
    while (nbytes < BYTE_TARGET) begin
      pick = $urandom_range(0, 9);
      build_tx($urandom_range(0, 1), $urandom_range(1, 4), $urandom_range(0, 3),
               ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0);
      if (pick == 6 || pick == 7) begin
        cut = $urandom_range(1, tx_bytes.size());
        while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
      end else if (pick == 8) begin
        tx_bytes[$urandom_range(0, tx_bytes.size() - 1)] = $urandom;
      end else if (pick == 9) begin
        tx_bytes.delete();
        repeat ($urandom_range(1, 40)) tx_bytes.push_back($urandom);
      end
      send_tx();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.tx_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    max_in = MAX_INPUTS_RESET;
    clear_parse();
    gaps_on = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_input_limit();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d transactions (%0d bytes) and checked %0d records,", ntx, nbytes,
             nrecords);
    $display("covering legacy and segwit layouts, truncation, oversized lengths and stalls.");
    if (nerr == 0 && pending_records.size() == 0) begin
      $display("tb_tx_input_witness_parser: PASS");
    end else begin
      $display("tb_tx_input_witness_parser: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tiwp_pkg.sv
rtl/core/tiwp_if.sv
rtl/core/tiwp_parser.sv
rtl/core/tiwp_queue.sv
rtl/core/tx_input_witness_parser.sv
test/tb_tx_input_witness_parser.sv
